/* rtl/core/wico_pkg.sv */
`default_nettype none
package wico_pkg;

    localparam int TABLE_W = 34;
    localparam int POS_W   = 9;
    localparam int CHAN_W  = 11;

    // element walk position: tag, length, then body bytes
    localparam logic [POS_W-1:0] POS_TAG   = 9'd0;
    localparam logic [POS_W-1:0] POS_LEN   = 9'd1;
    localparam logic [POS_W-1:0] POS_BODY0 = 9'd2;
    localparam logic [POS_W-1:0] POS_BODY1 = 9'd3;
    localparam logic [POS_W-1:0] POS_BODY2 = 9'd4;

    localparam logic [7:0] TAG_HT  = 8'd61;
    localparam logic [7:0] LEN_HT  = 8'd22;
    localparam logic [7:0] TAG_VHT = 8'd192;
    localparam logic [7:0] LEN_VHT = 8'd5;

    localparam logic [1:0] HT_SEC_ABOVE = 2'b01;
    localparam logic [1:0] HT_SEC_BELOW = 2'b11;
    localparam int         HT_40_BIT    = 2;

    localparam logic [7:0] VHT_W_NONE = 8'd0;
    localparam logic [7:0] VHT_W_160  = 8'd2;
    localparam logic [7:0] VHT_W_8080 = 8'd3;
    localparam logic [8:0] VHT_SEG_GAP = 9'd8;

    typedef logic signed [CHAN_W-1:0] chan_t;

    typedef struct packed {
        logic [7:0] ie_byte;
        logic       last;
        logic [6:0] link_quality;
    } in_word_t;

    typedef struct packed {
        logic [TABLE_W-1:0] channel_mask;
        logic [6:0]         quality_out;
    } out_word_t;

    typedef struct packed {
        logic       apply;
        logic [7:0] tag;
        logic [7:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } elem_t;

    // one-hot table position of a channel number, zero if not in the table
    function automatic logic [TABLE_W-1:0] chan_onehot(input chan_t c);
        logic [TABLE_W-1:0] m;
        logic [8:0]         q;
        m = '0;
        q = c[CHAN_W-1:2];
        if (c >= 11'sd1 && c <= 11'sd14) begin
            m[6'(c - 11'sd1)] = 1'b1;
        end else if (c >= 11'sd36 && c <= 11'sd64 && c[1:0] == 2'b00) begin
            m[6'(q + 9'd5)] = 1'b1;
        end else if (c >= 11'sd100 && c <= 11'sd144 && c[1:0] == 2'b00) begin
            m[6'(q - 9'd3)] = 1'b1;
        end
        return m;
    endfunction

    // channel plus two neighbors each side in the 2.4 GHz band (kept in 1..13)
    function automatic logic [TABLE_W-1:0] mark_onehot(input chan_t c);
        logic [TABLE_W-1:0] m;
        m = chan_onehot(c);
        if (c <= 11'sd14) begin
            if (c - 11'sd1 >= 11'sd1) m = m | chan_onehot(c - 11'sd1);
            if (c - 11'sd2 >= 11'sd1) m = m | chan_onehot(c - 11'sd2);
            if (c + 11'sd1 <= 11'sd13) m = m | chan_onehot(c + 11'sd1);
            if (c + 11'sd2 <= 11'sd13) m = m | chan_onehot(c + 11'sd2);
        end
        return m;
    endfunction

    // 20 MHz channels of an 80 MHz (4) or 160 MHz (8) block around a centre
    function automatic logic [TABLE_W-1:0] block_onehot(input logic [7:0] centre,
                                                        input logic wide);
        logic [TABLE_W-1:0] m;
        chan_t              base;
        m    = '0;
        base = wide ? (chan_t'({3'b000, centre}) - 11'sd14)
                    : (chan_t'({3'b000, centre}) - 11'sd6);
        for (int i = 0; i < 8; i++) begin
            if (wide || i < 4) begin
                m = m | mark_onehot(base + chan_t'(4 * i));
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/wico_elem_decode.sv */
`default_nettype none
module wico_elem_decode (
    input  wico_pkg::elem_t                  elem,
    output logic [wico_pkg::TABLE_W-1:0]     add_mask
);

    logic [wico_pkg::TABLE_W-1:0] ht_mask;
    logic [wico_pkg::TABLE_W-1:0] vht_mask;
    wico_pkg::chan_t              sec_chan;
    logic                         seg_adjacent;

    always_comb begin
        case (elem.b1[1:0])
            wico_pkg::HT_SEC_ABOVE: sec_chan = wico_pkg::chan_t'({3'b000, elem.b0}) + 11'sd4;
            wico_pkg::HT_SEC_BELOW: sec_chan = wico_pkg::chan_t'({3'b000, elem.b0}) - 11'sd4;
            default:                sec_chan = '0;
        endcase
    end

    always_comb begin
        ht_mask = '0;
        if (elem.tag == wico_pkg::TAG_HT && elem.len == wico_pkg::LEN_HT) begin
            ht_mask = wico_pkg::mark_onehot(wico_pkg::chan_t'({3'b000, elem.b0}));
            if (elem.b1[wico_pkg::HT_40_BIT]) begin
                ht_mask = ht_mask | wico_pkg::mark_onehot(sec_chan);
            end
        end
    end

    // the two 80 MHz centres sit 8 apart: one contiguous 160 MHz block
    assign seg_adjacent = ({1'b0, elem.b1} + wico_pkg::VHT_SEG_GAP == {1'b0, elem.b2})
                       || ({1'b0, elem.b2} + wico_pkg::VHT_SEG_GAP == {1'b0, elem.b1});

    always_comb begin
        vht_mask = '0;
        if (elem.tag == wico_pkg::TAG_VHT && elem.len == wico_pkg::LEN_VHT) begin
            case (elem.b0)
                wico_pkg::VHT_W_NONE: vht_mask = '0;
                wico_pkg::VHT_W_160:  vht_mask = wico_pkg::block_onehot(elem.b1, 1'b1);
                wico_pkg::VHT_W_8080: vht_mask = wico_pkg::block_onehot(elem.b1, 1'b0)
                                               | wico_pkg::block_onehot(elem.b2, 1'b0);
                default: begin
                    if (elem.b2 == 8'd0) begin
                        vht_mask = wico_pkg::block_onehot(elem.b1, 1'b0);
                    end else if (seg_adjacent) begin
                        vht_mask = wico_pkg::block_onehot(elem.b2, 1'b1);
                    end else begin
                        vht_mask = wico_pkg::block_onehot(elem.b1, 1'b0)
                                 | wico_pkg::block_onehot(elem.b2, 1'b0);
                    end
                end
            endcase
        end
    end

    assign add_mask = elem.apply ? (ht_mask | vht_mask) : '0;

endmodule
`default_nettype wire

/* rtl/core/wico_parser.sv */
`default_nettype none
module wico_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  wico_pkg::in_word_t               word,
    output logic [wico_pkg::TABLE_W-1:0]     occ_out
);

    logic [wico_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]                   tag_reg, tag_next;
    logic [7:0]                   len_reg, len_next;
    logic [7:0]                   b0_reg, b0_next;
    logic [7:0]                   b1_reg, b1_next;
    logic [7:0]                   b2_reg, b2_next;
    logic [wico_pkg::TABLE_W-1:0] occ_reg, occ_next;
    logic [wico_pkg::TABLE_W-1:0] add_mask;
    wico_pkg::elem_t              elem;
    logic                         body_done;

    // element is complete when the body byte just taken is its last one
    assign body_done = (pos_reg - 9'd1) >= {1'b0, len_reg};

    always_comb begin
        elem.tag   = tag_reg;
        elem.len   = (pos_reg == wico_pkg::POS_LEN)   ? word.ie_byte : len_reg;
        elem.b0    = (pos_reg == wico_pkg::POS_BODY0) ? word.ie_byte : b0_reg;
        elem.b1    = (pos_reg == wico_pkg::POS_BODY1) ? word.ie_byte : b1_reg;
        elem.b2    = (pos_reg == wico_pkg::POS_BODY2) ? word.ie_byte : b2_reg;
        elem.apply = 1'b0;
        if (step) begin
            if (pos_reg == wico_pkg::POS_LEN) begin
                elem.apply = (word.ie_byte == 8'd0);
            end else if (pos_reg != wico_pkg::POS_TAG) begin
                elem.apply = body_done;
            end
        end
    end

    wico_elem_decode u_decode (
        .elem     (elem),
        .add_mask (add_mask)
    );

    assign occ_out = occ_reg | add_mask;

    always_comb begin
        pos_next = pos_reg;
        tag_next = tag_reg;
        len_next = len_reg;
        b0_next  = b0_reg;
        b1_next  = b1_reg;
        b2_next  = b2_reg;
        occ_next = occ_reg;
        if (step) begin
            occ_next = occ_out;
            b0_next  = elem.b0;
            b1_next  = elem.b1;
            b2_next  = elem.b2;
            if (pos_reg == wico_pkg::POS_TAG) begin
                tag_next = word.ie_byte;
                pos_next = wico_pkg::POS_LEN;
            end else if (pos_reg == wico_pkg::POS_LEN) begin
                len_next = word.ie_byte;
                pos_next = (word.ie_byte == 8'd0) ? wico_pkg::POS_TAG : wico_pkg::POS_BODY0;
            end else begin
                pos_next = body_done ? wico_pkg::POS_TAG : pos_reg + 9'd1;
            end
            if (word.last) begin
                pos_next = wico_pkg::POS_TAG;
                tag_next = '0;
                len_next = '0;
                b0_next  = '0;
                b1_next  = '0;
                b2_next  = '0;
                occ_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= wico_pkg::POS_TAG;
            tag_reg <= '0;
            len_reg <= '0;
            b0_reg  <= '0;
            b1_reg  <= '0;
            b2_reg  <= '0;
            occ_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            tag_reg <= tag_next;
            len_reg <= len_next;
            b0_reg  <= b0_next;
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            occ_reg <= occ_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && word.last) |=> (occ_reg == '0 && pos_reg == wico_pkg::POS_TAG))
        else $error("parser state not cleared after last word");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 9'd257)
        else $error("element position past longest element");
`endif

endmodule
`default_nettype wire

/* rtl/core/wlan_ie_channel_occupancy.sv */
// The last word of an entry passes the input register, then the result register
// that drives m_valid. Throughput: one word per cycle unless a last word waits;
// the single-stage parser and element decoder sit between the two registers.
// A last word waits in the input register only while a prior result is unread.
// Reset (aresetn low, synchronous) empties both stages and clears parser state.
`default_nettype none
module wlan_ie_channel_occupancy #(
    parameter int NUM_TABLE_CHANNELS = 34
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  wico_pkg::in_word_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wico_pkg::out_word_t   m_data
);

    logic                         in_valid_reg, in_valid_next;
    wico_pkg::in_word_t           in_reg;
    logic                         m_valid_reg, m_valid_next;
    wico_pkg::out_word_t          m_data_reg;
    logic                         advance;
    logic                         emit;
    logic [wico_pkg::TABLE_W-1:0] occ_out;
    logic [wico_pkg::TABLE_W-1:0] chan_keep;

    always_comb begin
        for (int i = 0; i < wico_pkg::TABLE_W; i++) begin
            chan_keep[i] = (i < NUM_TABLE_CHANNELS);
        end
    end

    // a non-last word never needs the result register
    assign advance = in_valid_reg && (!in_reg.last || !m_valid_reg || m_ready);
    assign emit    = advance && in_reg.last;
    assign s_ready = !in_valid_reg || advance;

    wico_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .word    (in_reg),
        .occ_out (occ_out)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (emit) begin
            m_data_reg.channel_mask <= occ_out & chan_keep;
            m_data_reg.quality_out  <= in_reg.link_quality;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg && in_reg.last))
        else $error("result raised without a last word");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_reg.last && m_valid_reg && !m_ready)
            |=> (in_valid_reg && $stable(in_reg)))
        else $error("last word dropped while result stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_reg.last && m_valid_reg))
        else $error("input stalled without a pending result");
`endif

endmodule
`default_nettype wire

/* verif/tb_wlan_ie_channel_occupancy.sv */
`timescale 1ns / 1ps
module tb_wlan_ie_channel_occupancy;

    localparam int ITEM_TARGET    = 650;
    localparam int MIN_ENTRIES    = 20;
    localparam int MAX_WAIT       = 11;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 600;

    // 2.4 GHz band and the two 5 GHz groups of the channel table
    localparam int BAND24_TOP    = 14;
    localparam int BAND24_EDGE   = 13;
    localparam int LOW5_FIRST    = 36;
    localparam int LOW5_LAST     = 64;
    localparam int LOW5_SLOT     = 14;
    localparam int HIGH5_FIRST   = 100;
    localparam int HIGH5_LAST    = 144;
    localparam int HIGH5_SLOT    = 22;
    localparam int CHAN_STEP     = 4;
    localparam int HALF_80       = 6;
    localparam int HALF_160      = 14;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    wico_pkg::in_word_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    wico_pkg::out_word_t m_data;

    wlan_ie_channel_occupancy u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    wico_pkg::in_word_t  pending_bytes[$];
    wico_pkg::out_word_t expected_occupancy[$];
    logic [7:0]          entry_buf[$];
    int                  mismatches  = 0;
    int                  gap_left    = 0;
    int                  stall_left  = 0;
    int                  idle_cycles = 0;
    bit                  drv_calm    = 1'b0;
    bit                  mon_calm    = 1'b0;

    // predictor state
    logic [wico_pkg::POS_W-1:0]   walk_pos = wico_pkg::POS_TAG;
    logic [7:0]                   walk_tag = '0;
    logic [7:0]                   walk_len = '0;
    logic [7:0]                   body0    = '0;
    logic [7:0]                   body1    = '0;
    logic [7:0]                   body2    = '0;
    logic [wico_pkg::TABLE_W-1:0] occ_mask = '0;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int chan_slot(input int c);
        if (c >= 1 && c <= BAND24_TOP)
            return c - 1;
        if (c >= LOW5_FIRST && c <= LOW5_LAST && (c - LOW5_FIRST) % CHAN_STEP == 0)
            return LOW5_SLOT + (c - LOW5_FIRST) / CHAN_STEP;
        if (c >= HIGH5_FIRST && c <= HIGH5_LAST && (c - HIGH5_FIRST) % CHAN_STEP == 0)
            return HIGH5_SLOT + (c - HIGH5_FIRST) / CHAN_STEP;
        return -1;
    endfunction

    task automatic occupy(input int c);
        int slot;
        slot = chan_slot(c);
        if (slot >= 0 && slot < wico_pkg::TABLE_W)
            occ_mask[slot] = 1'b1;
    endtask

    // 2.4 GHz channels overlap two neighbors on each side
    task automatic occupy_with_neighbors(input int c);
        occupy(c);
        if (c <= BAND24_TOP) begin
            if (c - 1 >= 1) occupy(c - 1);
            if (c - 2 >= 1) occupy(c - 2);
            if (c + 1 <= BAND24_EDGE) occupy(c + 1);
            if (c + 2 <= BAND24_EDGE) occupy(c + 2);
        end
    endtask

    task automatic occupy_block(input int centre, input int half);
        for (int c = centre - half; c <= centre + half; c += CHAN_STEP)
            occupy_with_neighbors(c);
    endtask

    task automatic apply_element();
        int b0;
        int b1;
        int b2;
        int sec;
        int seg_gap;
        b0      = body0;
        b1      = body1;
        b2      = body2;
        seg_gap = wico_pkg::VHT_SEG_GAP;
        if (walk_tag == wico_pkg::TAG_HT && walk_len == wico_pkg::LEN_HT) begin
            case (body1[1:0])
                wico_pkg::HT_SEC_ABOVE: sec = b0 + CHAN_STEP;
                wico_pkg::HT_SEC_BELOW: sec = b0 - CHAN_STEP;
                default:                sec = 0;
            endcase
            occupy_with_neighbors(b0);
            if (body1[wico_pkg::HT_40_BIT])
                occupy_with_neighbors(sec);
        end
        if (walk_tag == wico_pkg::TAG_VHT && walk_len == wico_pkg::LEN_VHT
                && body0 != wico_pkg::VHT_W_NONE) begin
            if (body0 == wico_pkg::VHT_W_160) begin
                occupy_block(b1, HALF_160);
            end else if (body0 == wico_pkg::VHT_W_8080) begin
                occupy_block(b1, HALF_80);
                occupy_block(b2, HALF_80);
            end else if (b2 == 0) begin
                occupy_block(b1, HALF_80);
            end else if (b1 + seg_gap == b2 || b1 - seg_gap == b2) begin
                occupy_block(b2, HALF_160);
            end else begin
                occupy_block(b1, HALF_80);
                occupy_block(b2, HALF_80);
            end
        end
    endtask

    task automatic parse_byte(input wico_pkg::in_word_t w);
        wico_pkg::out_word_t res;
        if (walk_pos == wico_pkg::POS_TAG) begin
            walk_tag = w.ie_byte;
            walk_pos = wico_pkg::POS_LEN;
        end else if (walk_pos == wico_pkg::POS_LEN) begin
            walk_len = w.ie_byte;
            if (walk_len == 8'd0) begin
                apply_element();
                walk_pos = wico_pkg::POS_TAG;
            end else begin
                walk_pos = wico_pkg::POS_BODY0;
            end
        end else begin
            case (walk_pos)
                wico_pkg::POS_BODY0: body0 = w.ie_byte;
                wico_pkg::POS_BODY1: body1 = w.ie_byte;
                wico_pkg::POS_BODY2: body2 = w.ie_byte;
                default: ;
            endcase
            if (int'(walk_pos) - int'(wico_pkg::POS_BODY0) + 1 >= int'(walk_len)) begin
                apply_element();
                walk_pos = wico_pkg::POS_TAG;
            end else begin
                walk_pos = walk_pos + 1'b1;
            end
        end
        if (w.last) begin
            res.channel_mask = occ_mask;
            res.quality_out  = w.link_quality;
            expected_occupancy.insert(expected_occupancy.size(), res);
            walk_pos = wico_pkg::POS_TAG;
            walk_tag = '0;
            walk_len = '0;
            body0    = '0;
            body1    = '0;
            body2    = '0;
            occ_mask = '0;
        end
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 15))
            0:  return 8'd0;
            1:  return 8'd1;
            2:  return 8'd2;
            3:  return 8'd5;
            4:  return 8'd12;
            5:  return 8'd13;
            6:  return 8'd14;
            7:  return 8'd15;
            8:  return 8'd36;
            9:  return 8'd64;
            10: return 8'd100;
            11: return 8'd144;
            12: return 8'($urandom_range(1, 14));
            13: return 8'(LOW5_FIRST + CHAN_STEP * $urandom_range(0, 7));
            14: return 8'(HIGH5_FIRST + CHAN_STEP * $urandom_range(0, 11));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_centre();
        case ($urandom_range(0, 11))
            0:  return 8'd42;
            1:  return 8'd50;
            2:  return 8'd58;
            3:  return 8'd106;
            4:  return 8'd114;
            5:  return 8'd122;
            6:  return 8'd138;
            7:  return 8'd7;
            8:  return 8'd2;
            9:  return 8'd155;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [6:0] pick_quality();
        case ($urandom_range(0, 7))
            0:  return 7'd0;
            1:  return 7'd100;
            2:  return 7'($urandom_range(101, 127));
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b);
        entry_buf.insert(entry_buf.size(), b);
    endtask

    task automatic put_filler(input int n);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic put_ht(input logic [7:0] primary, input logic [7:0] info);
        put_byte(wico_pkg::TAG_HT);
        put_byte(wico_pkg::LEN_HT);
        put_byte(primary);
        put_byte(info);
        put_filler(int'(wico_pkg::LEN_HT) - 2);
    endtask

    task automatic put_vht(input logic [7:0] width, input logic [7:0] c1,
                           input logic [7:0] c2);
        put_byte(wico_pkg::TAG_VHT);
        put_byte(wico_pkg::LEN_VHT);
        put_byte(width);
        put_byte(c1);
        put_byte(c2);
        put_filler(int'(wico_pkg::LEN_VHT) - 3);
    endtask

    task automatic put_other(input logic [7:0] tag, input logic [7:0] len);
        put_byte(tag);
        put_byte(len);
        put_filler(int'(len));
    endtask

    task automatic send_entry(input logic [6:0] quality);
        wico_pkg::in_word_t w;
        for (int i = 0; i < entry_buf.size(); i++) begin
            w.ie_byte      = entry_buf[i];
            w.last         = (i == entry_buf.size() - 1);
            w.link_quality = w.last ? quality : 7'($urandom_range(0, 127));
            pending_bytes.insert(pending_bytes.size(), w);
        end
        entry_buf.delete();
    endtask

    task automatic build_random_entry();
        logic [7:0] width;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] info;
        int         cut;
        if ($urandom_range(0, 9) == 0) begin
            put_filler($urandom_range(1, 30));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        info = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 3) != 0)
                            info[wico_pkg::HT_40_BIT] = 1'b1;
                        put_ht(pick_channel(), info);
                    end
                    3, 4, 5, 6: begin
                        case ($urandom_range(0, 5))
                            0: width = wico_pkg::VHT_W_NONE;
                            1: width = 8'd1;
                            2: width = wico_pkg::VHT_W_160;
                            3: width = wico_pkg::VHT_W_8080;
                            default: width = 8'($urandom_range(0, 255));
                        endcase
                        c1 = pick_centre();
                        case ($urandom_range(0, 4))
                            0: c2 = 8'd0;
                            1: c2 = c1 + 8'(wico_pkg::VHT_SEG_GAP);
                            2: c2 = c1 - 8'(wico_pkg::VHT_SEG_GAP);
                            3: c2 = pick_centre();
                            default: c2 = 8'($urandom_range(0, 255));
                        endcase
                        put_vht(width, c1, c2);
                    end
                    7: put_other(8'd255, 8'($urandom_range(0, 8)));  // HE extension
                    8: put_other($urandom_range(0, 1) ? wico_pkg::TAG_HT : wico_pkg::TAG_VHT,
                                 8'($urandom_range(0, 8)));
                    default: begin
                        if ($urandom_range(0, 40) == 0)
                            put_other(8'($urandom_range(0, 255)), 8'($urandom_range(9, 255)));
                        else
                            put_other(8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)));
                    end
                endcase
            end
            // cut the entry short inside its elements
            if ($urandom_range(0, 4) == 0 && entry_buf.size() > 1) begin
                cut = $urandom_range(1, entry_buf.size() - 1);
                repeat (cut) void'(entry_buf.pop_back());
            end
        end
        send_entry(pick_quality());
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                parse_byte(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_bytes.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_bytes.pop_front();
                    if ($urandom_range(0, 23) == 0)
                        drv_calm = !drv_calm;
                    gap_left <= drv_calm ? 0 : $urandom_range(0, MAX_WAIT);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        wico_pkg::out_word_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_occupancy.size() == 0) begin
                    report_mismatch($sformatf("unexpected word mask=%h q=%0d",
                                              m_data.channel_mask, m_data.quality_out));
                end else begin
                    want = expected_occupancy.pop_front();
                    if (m_data.channel_mask !== want.channel_mask)
                        report_mismatch($sformatf("channel_mask got %h want %h",
                                                  m_data.channel_mask, want.channel_mask));
                    if (m_data.quality_out !== want.quality_out)
                        report_mismatch($sformatf("quality_out got %0d want %0d",
                                                  m_data.quality_out, want.quality_out));
                end
                if ($urandom_range(0, 23) == 0)
                    mon_calm = !mon_calm;
                stall_left = mon_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall_left != 0) begin
                m_ready    <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int entries;
        entries = 0;

        // tag byte alone on the last word: truncated element
        put_byte(8'hFF);
        send_entry(7'd100);
        // zero-length element, quality above 100 passes through
        put_other(8'h00, 8'h00);
        send_entry(7'd127);
        // VHT 160 MHz completing exactly on the last word
        put_vht(wico_pkg::VHT_W_160, 8'd50, 8'd0);
        send_entry(7'd0);
        // HT 40 MHz below channel 1: secondary lands off the table
        put_ht(8'd1, 8'h07);
        send_entry(7'd55);

        while (pending_bytes.size() < ITEM_TARGET || entries < MIN_ENTRIES) begin
            build_random_entry();
            entries++;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid || expected_occupancy.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/wico_pkg.sv
rtl/core/wico_elem_decode.sv
rtl/core/wico_parser.sv
rtl/core/wlan_ie_channel_occupancy.sv
verif/tb_wlan_ie_channel_occupancy.sv
